### rtl/core/crc32fc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 frame checker package
// Shared types, constants and the byte-wide CRC update.
// ----------------------------------------------------------------------------
package crc32fc_pkg;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;
  localparam logic [16:0] HdrBytes = 17'd32;
  localparam logic [16:0] MinFrame = 17'd36;
  localparam logic [16:0] IdxMax = 17'h1FFFF;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StTooLong  = 3'd2,
    StLenBad   = 3'd3,
    StCrcBad   = 3'd4,
    StVerBad   = 3'd5,
    StTypeBad  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    RegMaxPayload = 2'd0,
    RegVersion    = 2'd1,
    RegTypeMin    = 2'd2,
    RegTypeMax    = 2'd3
  } reg_e;

  typedef struct packed {
    logic [15:0] max_payload;
    logic [7:0]  expected_version;
    logic [7:0]  type_min;
    logic [7:0]  type_max;
  } cfg_t;

  // One queue entry handed from the front to the back part.
  typedef struct packed {
    logic        is_payload;
    logic        is_last;
    logic [7:0]  data;
    logic [16:0] len_total;
    logic [31:0] crc;
    logic [31:0] trailer;
    logic [7:0]  version;
    logic [7:0]  msg_type;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [15:0] src_id;
    logic [15:0] dst_id;
    logic [31:0] seq;
    logic [63:0] time_stamp;
    logic [15:0] len;
  } ent_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

### rtl/core/crc32_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 frame checker
// Parses framed packets, checks CRC and header, forwards payload bytes.
// ----------------------------------------------------------------------------
// Input channel: one frame byte per transfer (push/full), last marks the end.
// Result channel: payload byte results (kind 0) as payload bytes arrive, and
// one verdict (kind 1) carrying the header fields after the last byte.
// Payload results come before the verdict, so the receiver drops them if the
// verdict is not ok.
// Throughput is one byte per cycle while full is low: the byte-wide CRC
// update and header capture are done in the front end in the cycle of the
// transfer. Each result is written to a QueueDepth-entry queue and shown
// from its head; a last payload byte yields two results, the payload result
// first and then the verdict once the payload result is popped.
// When the receiver stalls, the queue fills and full rises; no data is lost.
// Reset clears the frame state and queue and loads the register defaults:
// max_payload 256, expected_version 1, type range 0 to 255.
// ----------------------------------------------------------------------------
module crc32_frame_checker #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic        pop,
  output logic        empty,
  output logic        kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [2:0]  status_o,
  output logic [7:0]  version_o,
  output logic [7:0]  msg_type_o,
  output logic [47:0] source_mac_o,
  output logic [47:0] dest_mac_o,
  output logic [15:0] source_id_o,
  output logic [15:0] dest_id_o,
  output logic [31:0] sequence_res_o,
  output logic [63:0] timestamp_o,
  output logic [15:0] payload_length_o
);

  crc32fc_pkg::cfg_t cfg_q;
  crc32fc_pkg::ent_t ent_in, ent_out;
  logic take, q_empty, q_pop;
  logic q_wr;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload      <= 16'd256;
      cfg_q.expected_version <= 8'd1;
      cfg_q.type_min         <= 8'd0;
      cfg_q.type_max         <= 8'd255;
    end else if (wr_en) begin
      case (crc32fc_pkg::reg_e'(paddr[3:2]))
        crc32fc_pkg::RegMaxPayload: cfg_q.max_payload <= pwdata[15:0];
        crc32fc_pkg::RegVersion:    cfg_q.expected_version <= pwdata[7:0];
        crc32fc_pkg::RegTypeMin:    cfg_q.type_min <= pwdata[7:0];
        crc32fc_pkg::RegTypeMax:    cfg_q.type_max <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (crc32fc_pkg::reg_e'(paddr[3:2]))
      crc32fc_pkg::RegMaxPayload: prdata = {16'd0, cfg_q.max_payload};
      crc32fc_pkg::RegVersion:    prdata = {24'd0, cfg_q.expected_version};
      crc32fc_pkg::RegTypeMin:    prdata = {24'd0, cfg_q.type_min};
      crc32fc_pkg::RegTypeMax:    prdata = {24'd0, cfg_q.type_max};
      default:                    prdata = '0;
    endcase
  end

  assign take = push && !full;
  // Header and trailer bytes that do not end the frame give no result.
  assign q_wr = take && (ent_in.is_payload || ent_in.is_last);

  crc32fc_front u_front (
    .clk_i, .rst_ni, .take_i(take), .data_byte_i, .last_i, .ent_o(ent_in)
  );

  crc32fc_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .wr_i(q_wr), .wdata_i(ent_in), .full_o(full),
    .rd_i(q_pop), .rdata_o(ent_out), .empty_o(q_empty)
  );

  crc32fc_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .ent_i(ent_out), .ent_empty_i(q_empty),
    .ent_pop_o(q_pop), .pop, .empty, .kind_o, .payload_byte_o, .status_o,
    .version_o, .msg_type_o, .source_mac_o, .dest_mac_o, .source_id_o,
    .dest_id_o, .sequence_res_o, .timestamp_o, .payload_length_o
  );

  a_pay_zero_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !kind_o) |-> status_o == 3'd0) else $error("payload with status");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> status_o != 3'd7) else $error("bad status code");
  a_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(kind_o))) else $error("result lost");

endmodule

### rtl/core/crc32fc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 frame checker front end
// Parses the header, runs the CRC and classifies each byte into a queue entry.
// ----------------------------------------------------------------------------
module crc32fc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_i,
  output crc32fc_pkg::ent_t   ent_o
);

  logic [16:0] idx_q, idx_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] trl_q, trl_d;
  logic [7:0]  ver_q, ver_d, typ_q, typ_d;
  logic [47:0] smac_q, smac_d, dmac_q, dmac_d;
  logic [15:0] sid_q, sid_d, did_q, did_d, len_q, len_d;
  logic [31:0] seq_q, seq_d;
  logic [63:0] tim_q, tim_d;
  logic        in_hdr, in_pay;

  always_comb begin
    in_hdr = idx_q < crc32fc_pkg::HdrBytes;
    in_pay = !in_hdr && ({1'b0, idx_q} < {1'b0, crc32fc_pkg::HdrBytes} + {2'b0, len_q});
    ver_d = ver_q; typ_d = typ_q; smac_d = smac_q; dmac_d = dmac_q;
    sid_d = sid_q; did_d = did_q; seq_d = seq_q; tim_d = tim_q; len_d = len_q;
    crc_d = crc_q; trl_d = trl_q;
    if (in_hdr) begin
      crc_d = crc32fc_pkg::crc_byte(crc_q, data_byte_i);
      if (idx_q == 17'd0) ver_d = data_byte_i;
      else if (idx_q == 17'd1) typ_d = data_byte_i;
      else if (idx_q < 17'd8) smac_d = {smac_q[39:0], data_byte_i};
      else if (idx_q < 17'd14) dmac_d = {dmac_q[39:0], data_byte_i};
      else if (idx_q < 17'd16) sid_d = {sid_q[7:0], data_byte_i};
      else if (idx_q < 17'd18) did_d = {did_q[7:0], data_byte_i};
      else if (idx_q < 17'd22) seq_d = {seq_q[23:0], data_byte_i};
      else if (idx_q < 17'd30) tim_d = {tim_q[55:0], data_byte_i};
      else len_d = {len_q[7:0], data_byte_i};
    end else if (in_pay) begin
      crc_d = crc32fc_pkg::crc_byte(crc_q, data_byte_i);
    end else begin
      trl_d = {trl_q[23:0], data_byte_i};
    end
    idx_d = (idx_q < crc32fc_pkg::IdxMax) ? idx_q + 17'd1 : idx_q;

    ent_o.is_payload = in_pay;
    ent_o.is_last    = last_i;
    ent_o.data       = data_byte_i;
    ent_o.len_total  = idx_d;
    ent_o.crc        = crc_d;
    ent_o.trailer    = trl_d;
    ent_o.version    = ver_d;
    ent_o.msg_type   = typ_d;
    ent_o.src_mac    = smac_d;
    ent_o.dst_mac    = dmac_d;
    ent_o.src_id     = sid_d;
    ent_o.dst_id     = did_d;
    ent_o.seq        = seq_d;
    ent_o.time_stamp = tim_d;
    ent_o.len        = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; crc_q <= crc32fc_pkg::CrcInit; trl_q <= '0;
      ver_q <= '0; typ_q <= '0; smac_q <= '0; dmac_q <= '0;
      sid_q <= '0; did_q <= '0; seq_q <= '0; tim_q <= '0; len_q <= '0;
    end else if (take_i) begin
      if (last_i) begin
        idx_q <= '0; crc_q <= crc32fc_pkg::CrcInit; trl_q <= '0;
        ver_q <= '0; typ_q <= '0; smac_q <= '0; dmac_q <= '0;
        sid_q <= '0; did_q <= '0; seq_q <= '0; tim_q <= '0; len_q <= '0;
      end else begin
        idx_q <= idx_d; crc_q <= crc_d; trl_q <= trl_d;
        ver_q <= ver_d; typ_q <= typ_d; smac_q <= smac_d; dmac_q <= dmac_d;
        sid_q <= sid_d; did_q <= did_d; seq_q <= seq_d; tim_q <= tim_d; len_q <= len_d;
      end
    end
  end

endmodule

### rtl/core/crc32fc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 frame checker entry queue
// A short register queue between the front end and the result stage.
// ----------------------------------------------------------------------------
module crc32fc_queue #(
  parameter int Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  crc32fc_pkg::ent_t wdata_i,
  output logic              full_o,
  input  logic              rd_i,
  output crc32fc_pkg::ent_t rdata_o,
  output logic              empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  crc32fc_pkg::ent_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = cnt_q == (AW + 1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (rd_i && !empty_o) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW + 1)'(wr_i && !full_o) - (AW + 1)'(rd_i && !empty_o);
    end
  end

endmodule

### rtl/core/crc32fc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 frame checker result stage
// Turns queue entries into payload results and frame verdicts.
// ----------------------------------------------------------------------------
module crc32fc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crc32fc_pkg::cfg_t  cfg_i,
  input  crc32fc_pkg::ent_t  ent_i,
  input  logic               ent_empty_i,
  output logic               ent_pop_o,
  input  logic               pop,
  output logic               empty,
  output logic               kind_o,
  output logic [7:0]         payload_byte_o,
  output logic [2:0]         status_o,
  output logic [7:0]         version_o,
  output logic [7:0]         msg_type_o,
  output logic [47:0]        source_mac_o,
  output logic [47:0]        dest_mac_o,
  output logic [15:0]        source_id_o,
  output logic [15:0]        dest_id_o,
  output logic [31:0]        sequence_res_o,
  output logic [63:0]        timestamp_o,
  output logic [15:0]        payload_length_o
);

  // An entry that is both payload and last gives the payload result first.
  logic pay_done_q;
  logic show_pay, has_verdict;
  crc32fc_pkg::status_e st;

  assign show_pay    = ent_i.is_payload && !pay_done_q;
  assign has_verdict = ent_i.is_last;
  assign empty       = ent_empty_i;
  assign ent_pop_o   = pop && !ent_empty_i && !(show_pay && has_verdict);

  always_comb begin
    if (ent_i.len_total < crc32fc_pkg::MinFrame) st = crc32fc_pkg::StShort;
    else if (ent_i.len > cfg_i.max_payload) st = crc32fc_pkg::StTooLong;
    else if (ent_i.len_total != crc32fc_pkg::MinFrame + {1'b0, ent_i.len})
      st = crc32fc_pkg::StLenBad;
    else if (~ent_i.crc != ent_i.trailer) st = crc32fc_pkg::StCrcBad;
    else if (ent_i.version != cfg_i.expected_version) st = crc32fc_pkg::StVerBad;
    else if (ent_i.msg_type < cfg_i.type_min || ent_i.msg_type > cfg_i.type_max)
      st = crc32fc_pkg::StTypeBad;
    else st = crc32fc_pkg::StOk;

    kind_o           = !show_pay;
    payload_byte_o   = show_pay ? ent_i.data : 8'd0;
    status_o         = show_pay ? 3'd0 : st;
    version_o        = show_pay ? 8'd0 : ent_i.version;
    msg_type_o       = show_pay ? 8'd0 : ent_i.msg_type;
    source_mac_o     = show_pay ? 48'd0 : ent_i.src_mac;
    dest_mac_o       = show_pay ? 48'd0 : ent_i.dst_mac;
    source_id_o      = show_pay ? 16'd0 : ent_i.src_id;
    dest_id_o        = show_pay ? 16'd0 : ent_i.dst_id;
    sequence_res_o   = show_pay ? 32'd0 : ent_i.seq;
    timestamp_o      = show_pay ? 64'd0 : ent_i.time_stamp;
    payload_length_o = show_pay ? 16'd0 : ent_i.len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pay_done_q <= 1'b0;
    end else if (pop && !ent_empty_i) begin
      pay_done_q <= show_pay && has_verdict;
    end
  end

endmodule
